// ===== sv/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared constants and codes for the integer alu with modular power.
// ----------------------------------------------------------------------------
package ialu_pkg;

   localparam int WORD_WIDTH_DEFAULT = 32;

   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_SUB    = 3'd1;
   localparam logic [2:0] FUNC_MUL    = 3'd2;
   localparam logic [2:0] FUNC_DIV    = 3'd3;
   localparam logic [2:0] FUNC_REM    = 3'd4;
   localparam logic [2:0] FUNC_POW    = 3'd5;
   localparam logic [2:0] FUNC_MPOW   = 3'd6;
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO    = 2'd1;
   localparam logic [1:0] STATUS_NEG_EXP = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_PSTEP = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_MREM  = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_MINIT = 7'b1000000
   } state_type;

   // which product the power loops are working on
   typedef enum logic [1:0] {
      MOP_BASE_RED = 2'b01,
      MOP_RES      = 2'b10,
      MOP_SQ       = 2'b11
   } mop_type;

endpackage

// ===== sv/integer_alu_with_modular_power.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_modular_power
// Signed integer alu: add, subtract, multiply, divide, remainder, power and
// modular power, built around a shared add/subtract unit; the modular step has its own reduce subtractors.
// ----------------------------------------------------------------------------
// Usage: present func, operand_a, operand_b and modulus on the req_ channel
// with req_valid; the item is taken when req_valid and req_ready are high.
// One item gives exactly one rsp_ item carrying rsp_result and rsp_status.
// The block works on one item at a time: req_ready is high only when idle.
// Steps: add, subtract and the error cases go straight from idle to the done
// state. Multiply does one shift-add step per bit. Divide and remainder do
// one restoring step per bit. Power does up to two multiplies per exponent
// bit up to its highest set bit. Modular power first reduces the base, then
// does up to two multiply-reduces per exponent bit, each a serial modular
// multiply-add loop over the bits of the multiplier.
// The result is held in an output register until rsp_ready; while the
// receiver stalls the block stays in its done state and takes no item.
// Reset returns the sequencer to idle and drops rsp_valid; no data clears.
// ----------------------------------------------------------------------------
module integer_alu_with_modular_power #(
   parameter int WORD_WIDTH = ialu_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_func,
   input  logic signed [WORD_WIDTH-1:0] req_operand_a,
   input  logic signed [WORD_WIDTH-1:0] req_operand_b,
   input  logic signed [WORD_WIDTH-1:0] req_modulus,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [WORD_WIDTH-1:0] rsp_result,
   output logic [1:0]                   rsp_status
);

   localparam int W  = WORD_WIDTH;
   localparam int CW = $clog2(W + 1);

   ialu_pkg::state_type state_ff, state_in;
   ialu_pkg::mop_type   mop_ff, mop_in;

   logic [2:0]   func_ff, func_in;
   logic [W-1:0] res_ff, res_in;       // result / accumulator
   logic [W-1:0] base_ff, base_in;     // power base / modular base
   logic [W-1:0] exp_ff, exp_in;       // remaining exponent
   logic [W-1:0] mm_ff, mm_in;         // |modulus| or |divisor|
   logic [W-1:0] mx_ff, mx_in;         // multiplicand (magnitude in modular steps)
   logic [W-1:0] my_ff, my_in;         // multiplier / dividend shifter
   logic [W:0]   acc_ff, acc_in;       // partial remainder / product
   logic [W-1:0] quo_ff, quo_in;
   logic         neg_ff, neg_in;       // sign to apply to step result
   logic         rneg_ff, rneg_in;     // remainder sign for divide/rem
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]   status_ff, status_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // shared adder: one add or subtract per cycle
   logic [W:0] add_a, add_b, add_sum;
   logic       add_sub;

   logic [W-1:0] ua, ub, um;
   logic [W:0]   step_sh, step_red, step_add, step_red2;
   logic [W-1:0] mul_next;

   always_comb begin
      add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
   end

   assign ua = req_operand_a[W-1] ? (~req_operand_a + 1'b1) : req_operand_a;
   assign ub = req_operand_b[W-1] ? (~req_operand_b + 1'b1) : req_operand_b;
   assign um = req_modulus[W-1]   ? (~req_modulus + 1'b1)   : req_modulus;

   assign req_ready  = (state_ff == ialu_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;
   assign rsp_status = status_ff;

   always_comb begin
      state_in     = state_ff;
      mop_in       = mop_ff;
      func_in      = func_ff;
      res_in       = res_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      mm_in        = mm_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      rneg_in      = rneg_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      add_a        = '0;
      add_b        = '0;
      add_sub      = 1'b0;
      step_sh      = '0;
      step_red     = '0;
      step_add     = '0;
      step_red2    = '0;
      mul_next     = '0;

      case (state_ff)
         ialu_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               status_in = ialu_pkg::STATUS_OK;
               res_in    = '0;
               cnt_in    = CW'(W);
               acc_in    = '0;
               state_in  = ialu_pkg::ST_DONE;
               case (req_func)
                  ialu_pkg::FUNC_ADD: begin
                     add_a  = {1'b0, req_operand_a};
                     add_b  = {1'b0, req_operand_b};
                     res_in = add_sum[W-1:0];
                  end
                  ialu_pkg::FUNC_SUB: begin
                     add_a   = {1'b0, req_operand_a};
                     add_b   = {1'b0, req_operand_b};
                     add_sub = 1'b1;
                     res_in  = add_sum[W-1:0];
                  end
                  ialu_pkg::FUNC_MUL: begin
                     mx_in    = req_operand_a;
                     my_in    = req_operand_b;
                     state_in = ialu_pkg::ST_MUL;
                  end
                  ialu_pkg::FUNC_DIV, ialu_pkg::FUNC_REM: begin
                     if (req_operand_b == '0) begin
                        status_in = ialu_pkg::STATUS_ZERO;
                     end else begin
                        my_in    = ua;
                        mm_in    = ub;
                        quo_in   = '0;
                        neg_in   = req_operand_a[W-1] ^ req_operand_b[W-1];
                        rneg_in  = req_operand_a[W-1];
                        state_in = ialu_pkg::ST_DIV;
                     end
                  end
                  ialu_pkg::FUNC_POW: begin
                     if (req_operand_b[W-1]) begin
                        status_in = ialu_pkg::STATUS_NEG_EXP;
                     end else begin
                        res_in   = W'(1);
                        base_in  = req_operand_a;
                        exp_in   = req_operand_b;
                        state_in = ialu_pkg::ST_PSTEP;
                     end
                  end
                  ialu_pkg::FUNC_MPOW: begin
                     if (req_modulus == '0) begin
                        status_in = ialu_pkg::STATUS_ZERO;
                     end else if (req_operand_b[W-1]) begin
                        status_in = ialu_pkg::STATUS_NEG_EXP;
                     end else begin
                        mm_in    = um;
                        res_in   = (um == W'(1)) ? '0 : W'(1);
                        exp_in   = req_operand_b;
                        // base = a rem m via a multiply-reduce of 1 by |a|
                        mx_in    = W'(1);
                        my_in    = ua;
                        neg_in   = req_operand_a[W-1];
                        mop_in   = ialu_pkg::MOP_BASE_RED;
                        state_in = ialu_pkg::ST_MREM;
                     end
                  end
                  default: ;
               endcase
               rsp_valid_in = (state_in == ialu_pkg::ST_DONE);
            end
         end

         // restoring division, one bit per cycle
         ialu_pkg::ST_DIV: begin
            step_sh = {acc_ff[W-1:0], my_ff[W-1]};
            add_a   = step_sh;
            add_b   = {1'b0, mm_ff};
            add_sub = 1'b1;
            my_in   = {my_ff[W-2:0], 1'b0};
            if (!add_sum[W]) begin
               acc_in = add_sum;
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               acc_in = step_sh;
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               if (func_ff == ialu_pkg::FUNC_DIV) begin
                  res_in = neg_ff ? (~quo_in + 1'b1) : quo_in;
               end else begin
                  res_in = rneg_ff ? (~acc_in[W-1:0] + 1'b1) : acc_in[W-1:0];
               end
               state_in     = ialu_pkg::ST_DONE;
               rsp_valid_in = 1'b1;
            end
         end

         // one exponent bit: queue up the multiplies it needs, or finish at zero
         ialu_pkg::ST_PSTEP: begin
            if (exp_ff == '0) begin
               state_in     = ialu_pkg::ST_DONE;
               rsp_valid_in = 1'b1;
            end else begin
               cnt_in   = CW'(W);
               acc_in   = '0;
               mx_in    = exp_ff[0] ? res_ff : base_ff;
               my_in    = base_ff;
               mop_in   = exp_ff[0] ? ialu_pkg::MOP_RES : ialu_pkg::MOP_SQ;
               state_in = (func_ff == ialu_pkg::FUNC_POW) ?
                          ialu_pkg::ST_MUL : ialu_pkg::ST_MINIT;
            end
         end

         // wrapping shift-add multiply, lsb first
         ialu_pkg::ST_MUL: begin
            add_a    = acc_ff;
            add_b    = my_ff[0] ? {1'b0, mx_ff} : '0;
            acc_in   = add_sum;
            mx_in    = {mx_ff[W-2:0], 1'b0};
            my_in    = {1'b0, my_ff[W-1:1]};
            cnt_in   = cnt_ff - 1'b1;
            mul_next = add_sum[W-1:0];
            if (cnt_ff == CW'(1)) begin
               if (func_ff == ialu_pkg::FUNC_MUL) begin
                  res_in       = mul_next;
                  state_in     = ialu_pkg::ST_DONE;
                  rsp_valid_in = 1'b1;
               end else if (mop_ff == ialu_pkg::MOP_RES) begin
                  res_in   = mul_next;
                  mop_in   = ialu_pkg::MOP_SQ;
                  mx_in    = base_ff;
                  my_in    = base_ff;
                  acc_in   = '0;
                  cnt_in   = CW'(W);
               end else begin
                  base_in  = mul_next;
                  exp_in   = {1'b0, exp_ff[W-1:1]};
                  state_in = ialu_pkg::ST_PSTEP;
               end
            end
         end

         // set up magnitudes and sign for a modular multiply
         ialu_pkg::ST_MINIT: begin
            neg_in = mx_ff[W-1] ^ my_ff[W-1];
            mx_in  = mx_ff[W-1] ? (~mx_ff + 1'b1) : mx_ff;
            my_in  = my_ff[W-1] ? (~my_ff + 1'b1) : my_ff;
            acc_in = '0;
            cnt_in = CW'(W);
            state_in = ialu_pkg::ST_MREM;
         end

         // modular multiply, msb first: double, reduce, add, reduce
         ialu_pkg::ST_MREM: begin
            step_sh = {acc_ff[W-1:0], 1'b0};
            step_red = (step_sh >= {1'b0, mm_ff}) ? (step_sh - {1'b0, mm_ff}) : step_sh;
            add_a    = step_red;
            add_b    = my_ff[W-1] ? {1'b0, mx_ff} : '0;
            step_add = add_sum;
            step_red2 = (step_add >= {1'b0, mm_ff}) ?
                        (step_add - {1'b0, mm_ff}) : step_add;
            acc_in = step_red2;
            my_in  = {my_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               mul_next = (neg_ff && step_red2 != '0) ?
                          (~step_red2[W-1:0] + 1'b1) : step_red2[W-1:0];
               cnt_in = CW'(W);
               acc_in = '0;
               case (mop_ff)
                  ialu_pkg::MOP_RES: begin
                     res_in   = mul_next;
                     mop_in   = ialu_pkg::MOP_SQ;
                     mx_in    = base_ff;
                     my_in    = base_ff;
                     state_in = ialu_pkg::ST_MINIT;
                  end
                  ialu_pkg::MOP_SQ: begin
                     base_in  = mul_next;
                     exp_in   = {1'b0, exp_ff[W-1:1]};
                     state_in = ialu_pkg::ST_PSTEP;
                  end
                  default: begin
                     base_in  = mul_next;
                     state_in = ialu_pkg::ST_PSTEP;
                  end
               endcase
            end
         end

         ialu_pkg::ST_DONE: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ialu_pkg::ST_IDLE;
            end
         end

         default: state_in = ialu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ialu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mop_ff    <= mop_in;
      func_ff   <= func_in;
      res_ff    <= res_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      mm_ff     <= mm_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      rneg_ff   <= rneg_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
   end

endmodule

// ===== sim/tb_integer_alu_with_modular_power.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_alu_with_modular_power
// Drives directed and random operations through the alu and checks every
// result and status against a behavioural model of the arithmetic.
// ----------------------------------------------------------------------------
module tb_integer_alu_with_modular_power;

   localparam int W = ialu_pkg::WORD_WIDTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int TAIL_CYCLES = 50;
   localparam int LONG_STALL = 400;

   typedef struct packed {
      logic [2:0]   func;
      logic [W-1:0] a;
      logic [W-1:0] b;
      logic [W-1:0] m;
   } alu_op_type;

   typedef struct packed {
      logic [W-1:0] result;
      logic [1:0]   status;
   } alu_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_func = '0;
   logic signed [W-1:0] req_operand_a = '0;
   logic signed [W-1:0] req_operand_b = '0;
   logic signed [W-1:0] req_modulus = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_result;
   logic [1:0] rsp_status;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int errors = 0;
   int results_seen = 0;
   int ops_sent = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_off = 0;
   bit stall_done = 1'b0;

   always #2 clock = ~clock;

   integer_alu_with_modular_power #(.WORD_WIDTH(W)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_modulus(req_modulus),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result(rsp_result), .rsp_status(rsp_status)
   );

   // 64-bit helpers working on sign-extended values
   function automatic logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [63:0] signed_rem(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      r = magnitude(x) % magnitude(y);
      return x[63] ? -r : r;
   endfunction

   // exact product of x and y reduced by mm, sign of the product
   function automatic logic [63:0] mul_reduce(logic [63:0] x, logic [63:0] y,
                                              logic [63:0] mm);
      logic [127:0] p;
      logic [63:0] r;
      p = magnitude(x) * magnitude(y);
      r = p % mm;
      if ((x[63] ^ y[63]) && r != 0) r = -r;
      return r;
   endfunction

   function automatic alu_res_type alu_predict(alu_op_type op);
      logic [63:0] a, b, m, r, base, e, mm;
      alu_res_type o;
      a = {{(64-W){op.a[W-1]}}, op.a};
      b = {{(64-W){op.b[W-1]}}, op.b};
      m = {{(64-W){op.m[W-1]}}, op.m};
      r = 0;
      o.status = ialu_pkg::STATUS_OK;
      case (op.func)
         ialu_pkg::FUNC_ADD: r = a + b;
         ialu_pkg::FUNC_SUB: r = a - b;
         ialu_pkg::FUNC_MUL: r = a * b;
         ialu_pkg::FUNC_DIV: begin
            if (b == 0) o.status = ialu_pkg::STATUS_ZERO;
            else begin
               r = magnitude(a) / magnitude(b);
               if (a[63] ^ b[63]) r = -r;
            end
         end
         ialu_pkg::FUNC_REM: begin
            if (b == 0) o.status = ialu_pkg::STATUS_ZERO;
            else r = signed_rem(a, b);
         end
         ialu_pkg::FUNC_POW: begin
            if (b[63]) o.status = ialu_pkg::STATUS_NEG_EXP;
            else begin
               r = 1;
               base = a;
               for (e = b; e != 0; e = e >> 1) begin
                  if (e[0]) r = r * base;
                  base = base * base;
               end
            end
         end
         ialu_pkg::FUNC_MPOW: begin
            if (m == 0) o.status = ialu_pkg::STATUS_ZERO;
            else if (b[63]) o.status = ialu_pkg::STATUS_NEG_EXP;
            else begin
               mm = magnitude(m);
               r = (mm == 1) ? 0 : 1;
               base = signed_rem(a, m);
               for (e = b; e != 0; e = e >> 1) begin
                  if (e[0]) r = mul_reduce(r, base, mm);
                  base = mul_reduce(base, base, mm);
               end
            end
         end
         default: r = 0;
      endcase
      if (o.status != ialu_pkg::STATUS_OK) r = 0;
      o.result = r[W-1:0];
      return o;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20);
         1: return -$urandom_range(1, 20);
         2: return {1'b1, {(W-1){1'b0}}};
         3: return {1'b0, {(W-1){1'b1}}};
         default: return $urandom;
      endcase
   endfunction

   task automatic add_op(logic [2:0] f, logic [W-1:0] a, logic [W-1:0] b,
                         logic [W-1:0] m);
      alu_op_type op;
      op.func = f;
      op.a = a;
      op.b = b;
      op.m = m;
      pending_ops.push_back(op);
   endtask

   // driver
   always @(posedge clock) begin
      alu_op_type op;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(alu_predict({req_func, req_operand_a,
                                                    req_operand_b, req_modulus}));
            ops_sent <= ops_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_ops.size() > 0) begin
               op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_func <= op.func;
               req_operand_a <= op.a;
               req_operand_b <= op.b;
               req_modulus <= op.m;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      alu_res_type exp_r;
      int bad;
      bad = 0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               bad = 1;
               $display("%0t: unexpected result %h status %0d", $time,
                        rsp_result, rsp_status);
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r.result !== rsp_result) begin
                  bad = bad + 1;
                  $display("%0t: result expected %h actual %h", $time,
                           exp_r.result, rsp_result);
               end
               if (exp_r.status !== rsp_status) begin
                  bad = bad + 1;
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_r.status, rsp_status);
               end
            end
            errors <= errors + bad;
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else if (!stall_done && ops_sent >= 40) begin
            // long stall so the block fills and holds off the sender
            hold_off <= LONG_STALL;
            stall_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready && ops_sent > 150) recv_gap <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [W-1:0] minv, maxv;
      int fsel;
      minv = {1'b1, {(W-1){1'b0}}};
      maxv = {1'b0, {(W-1){1'b1}}};
      // directed: extremes and every special case
      add_op(ialu_pkg::FUNC_ADD, maxv, 1, 0);
      add_op(ialu_pkg::FUNC_SUB, minv, 1, '1);
      add_op(ialu_pkg::FUNC_MUL, minv, '1, 0);
      add_op(ialu_pkg::FUNC_MUL, maxv, maxv, 0);
      add_op(ialu_pkg::FUNC_DIV, 100, 0, 0);
      add_op(ialu_pkg::FUNC_DIV, minv, '1, 0);
      add_op(ialu_pkg::FUNC_DIV, -7, 2, 0);
      add_op(ialu_pkg::FUNC_REM, -7, 2, 0);
      add_op(ialu_pkg::FUNC_REM, 7, -2, 0);
      add_op(ialu_pkg::FUNC_REM, minv, '1, 0);
      add_op(ialu_pkg::FUNC_REM, 5, 0, 0);
      add_op(ialu_pkg::FUNC_POW, 3, 0, 0);
      add_op(ialu_pkg::FUNC_POW, -3, 5, 0);
      add_op(ialu_pkg::FUNC_POW, 3, -1, 0);
      add_op(ialu_pkg::FUNC_POW, 2, 31, 0);
      add_op(ialu_pkg::FUNC_MPOW, 3, -1, 0);
      add_op(ialu_pkg::FUNC_MPOW, 3, 5, 0);
      add_op(ialu_pkg::FUNC_MPOW, 3, 5, -7);
      add_op(ialu_pkg::FUNC_MPOW, -3, 3, 7);
      add_op(ialu_pkg::FUNC_MPOW, 100, 3, 7);
      add_op(ialu_pkg::FUNC_MPOW, 9, 0, 1);
      add_op(ialu_pkg::FUNC_MPOW, 9, 0, '1);
      add_op(ialu_pkg::FUNC_MPOW, minv, maxv, maxv);
      add_op(ialu_pkg::FUNC_MPOW, maxv, maxv, minv);
      add_op(ialu_pkg::FUNC_UNUSED, '1, '1, '1);
      for (int i = 0; i < 245; i++) begin
         fsel = $urandom_range(0, 7);
         add_op(fsel[2:0], rand_word(), rand_word(), rand_word());
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d items over all operation codes, with extremes,", ops_sent);
      $display("error cases and a long receiver stall; %0d results checked", results_seen);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ialu_pkg.sv
sv/integer_alu_with_modular_power.sv
sim/tb_integer_alu_with_modular_power.sv
